>>> hdl/srde_pkg.sv
// Shared types and constants of the sparse row dot engine.
`default_nettype none

package srde_pkg;

	localparam int VECTOR_DEPTH_DEF = 1024;
	localparam int MAX_ROWS_DEF     = 1024;
	localparam int QUEUE_DEPTH      = 4;

	localparam int INDEX_W = 10;
	localparam int WORD_W  = 32;
	localparam int ROW_W   = 10;
	localparam int MODE_W  = 2;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 48;

	typedef enum logic [MODE_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_MAC   = 2'd1,
		OP_EMPTY = 2'd2
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [WORD_W-1:0] value;
		logic [WORD_W-1:0] elem;
		logic              last;
	} q_entry_t;

endpackage

`default_nettype wire

>>> hdl/sparse_row_dot_engine_core.sv
// Top level of the sparse row dot engine: front end, queue and back end.
//
//  channel  dir  tdata (low bit up)            tuser      tlast
//  s_*      in   index[9:0], value[41:10]      mode[1:0]  row_end
//  m_*      out  row_number[9:0], row_sum[41:10]  -       -
//
//  One item per cycle while m_tready stays high; mode 3 items are dropped.
//  An input transfer reaches the result through the front stage with
//  registered vector store read, the queue slot, the multiply stage and the result register.
//  arst_n clears control state; the vector store holds no reset value.
//  A stalled output fills the queue first, then the front stops s_tready.
`default_nettype none

module sparse_row_dot_engine_core #(
	parameter int VECTOR_DEPTH = srde_pkg::VECTOR_DEPTH_DEF,
	parameter int MAX_ROWS     = srde_pkg::MAX_ROWS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [srde_pkg::IN_DATA_W-1:0]  s_tdata,  // index, value
	input  wire logic [srde_pkg::MODE_W-1:0]     s_tuser,  // mode
	input  wire logic                            s_tlast,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [srde_pkg::OUT_DATA_W-1:0]      m_tdata   // row_number, row_sum
);

	logic               push_valid;
	logic               push_ready;
	srde_pkg::q_entry_t push_entry;
	logic               pop_valid;
	logic               pop_ready;
	srde_pkg::q_entry_t pop_entry;

	srde_front #(
		.VECTOR_DEPTH(VECTOR_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	srde_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push_valid),
		.in_ready  (push_ready),
		.in_entry  (push_entry),
		.out_valid (pop_valid),
		.out_ready (pop_ready),
		.out_entry (pop_entry)
	);

	srde_back #(
		.MAX_ROWS(MAX_ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

`default_nettype wire

>>> hdl/srde_front.sv
// Front end: input transfer, classification and vector store access.
`default_nettype none

module srde_front #(
	parameter int VECTOR_DEPTH = srde_pkg::VECTOR_DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [srde_pkg::IN_DATA_W-1:0]   s_tdata,
	input  wire logic [srde_pkg::MODE_W-1:0]      s_tuser,
	input  wire logic                             s_tlast,
	output logic                                  push_valid,
	input  wire logic                             push_ready,
	output srde_pkg::q_entry_t                    push_entry
);

	localparam int AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

	logic [srde_pkg::WORD_W-1:0] store [VECTOR_DEPTH];

	logic [srde_pkg::INDEX_W-1:0] index;
	logic [srde_pkg::WORD_W-1:0]  value;
	logic [31:0]                  index_ext;
	logic [AW-1:0]                addr;
	logic                         in_range;
	logic                         accept;
	logic                         keep;
	logic                         wr_en;

	logic                         valid_s1;
	srde_pkg::op_t                op_s1;
	logic [srde_pkg::WORD_W-1:0]  value_s1;
	logic                         last_s1;
	logic                         in_range_s1;
	logic [srde_pkg::WORD_W-1:0]  rd_data_q;

	assign index     = s_tdata[srde_pkg::INDEX_W-1:0];
	assign value     = s_tdata[srde_pkg::INDEX_W +: srde_pkg::WORD_W];
	assign index_ext = {{(32-srde_pkg::INDEX_W){1'b0}}, index};
	assign addr      = index_ext[AW-1:0];
	assign in_range  = index_ext < 32'(VECTOR_DEPTH);

	assign s_tready = !valid_s1 || push_ready;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		unique case (s_tuser)
			srde_pkg::OP_LOAD:  keep = 1'b1;
			srde_pkg::OP_MAC:   keep = 1'b1;
			srde_pkg::OP_EMPTY: keep = 1'b1;
			default:            keep = 1'b0;
		endcase
	end

	assign wr_en = accept && (s_tuser == srde_pkg::OP_LOAD) && in_range;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store[addr] <= value;
		end
		if (accept) begin
			rd_data_q <= store[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && keep) begin
			op_s1       <= srde_pkg::op_t'(s_tuser);
			value_s1    <= value;
			last_s1     <= s_tlast;
			in_range_s1 <= in_range;
		end
	end

	assign push_valid       = valid_s1;
	assign push_entry.op    = op_s1;
	assign push_entry.value = value_s1;
	assign push_entry.elem  = in_range_s1 ? rd_data_q : '0;
	assign push_entry.last  = last_s1;

endmodule

`default_nettype wire

>>> hdl/srde_queue.sv
// Short queue between front end and back end.
`default_nettype none

module srde_queue (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  srde_pkg::q_entry_t in_entry,
	output logic             out_valid,
	input  wire logic        out_ready,
	output srde_pkg::q_entry_t out_entry
);

	localparam int PW = $clog2(srde_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(srde_pkg::QUEUE_DEPTH + 1);

	srde_pkg::q_entry_t slots [srde_pkg::QUEUE_DEPTH];

	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign in_ready  = count_q != CW'(srde_pkg::QUEUE_DEPTH);
	assign out_valid = count_q != '0;
	assign out_entry = slots[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_ptr_q] <= in_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(srde_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(srde_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(srde_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not grow on push");

endmodule

`default_nettype wire

>>> hdl/srde_back.sv
// Back end: multiply, row accumulation and result register.
`default_nettype none

module srde_back #(
	parameter int MAX_ROWS = srde_pkg::MAX_ROWS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            pop_valid,
	output logic                                 pop_ready,
	input  srde_pkg::q_entry_t                   pop_entry,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [srde_pkg::OUT_DATA_W-1:0]      m_tdata
);

	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	logic                        valid_s2;
	srde_pkg::op_t               op_s2;
	logic [srde_pkg::WORD_W-1:0] prod_s2;
	logic                        last_s2;

	logic [srde_pkg::WORD_W-1:0] acc_q;
	logic [RW-1:0]               row_q;
	logic                        out_valid_q;
	logic [srde_pkg::ROW_W-1:0]  out_row_q;
	logic [srde_pkg::WORD_W-1:0] out_sum_q;

	logic                        out_free;
	logic                        s2_emit;
	logic                        s2_go;
	logic [srde_pkg::WORD_W-1:0] sum;
	logic [RW-1:0]               row_next;
	logic [31:0]                 row_ext;

	assign out_free  = !out_valid_q || m_tready;
	assign s2_emit   = (op_s2 == srde_pkg::OP_EMPTY) || ((op_s2 == srde_pkg::OP_MAC) && last_s2);
	assign s2_go     = valid_s2 && (!s2_emit || out_free);
	assign pop_ready = !valid_s2 || s2_go;
	assign sum       = acc_q + prod_s2;
	assign row_next  = (row_q == RW'(MAX_ROWS - 1)) ? '0 : row_q + 1'b1;
	assign row_ext   = 32'(row_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (pop_ready) begin
			valid_s2 <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			op_s2   <= pop_entry.op;
			prod_s2 <= pop_entry.value * pop_entry.elem;
			last_s2 <= pop_entry.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (s2_go) begin
				unique case (op_s2)
					srde_pkg::OP_LOAD: begin
						acc_q <= '0;
						row_q <= '0;
					end
					srde_pkg::OP_MAC: begin
						if (last_s2) begin
							acc_q       <= '0;
							row_q       <= row_next;
							out_valid_q <= 1'b1;
						end else begin
							acc_q <= sum;
						end
					end
					srde_pkg::OP_EMPTY: begin
						acc_q       <= '0;
						row_q       <= row_next;
						out_valid_q <= 1'b1;
					end
					default: begin
						acc_q <= acc_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go && s2_emit) begin
			out_row_q <= row_ext[srde_pkg::ROW_W-1:0];
			out_sum_q <= (op_s2 == srde_pkg::OP_EMPTY) ? '0 : sum;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(srde_pkg::OUT_DATA_W - srde_pkg::ROW_W - srde_pkg::WORD_W){1'b0}},
		out_sum_q, out_row_q};

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_go && op_s2 == srde_pkg::OP_EMPTY) |=> (out_valid_q && out_sum_q == '0))
		else $error("empty row did not give a zero sum");

	a_load_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_go && op_s2 == srde_pkg::OP_LOAD) |=> (acc_q == '0 && row_q == '0))
		else $error("vector load did not restart rows");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_ext < 32'(MAX_ROWS))
		else $error("row counter beyond row count");

endmodule

`default_nettype wire
